[design/sos_pkg.sv]
// ----------------------------------------------------------------------------
// sos_pkg
// Shared widths, register map, controller states and the command/status
// structs that join the segmenter controller and datapath.
// ----------------------------------------------------------------------------
package sos_pkg;

    localparam int ANGLE_W  = 9;
    localparam int DIST_W   = 16;
    localparam int HITS_W   = 9;
    localparam int SUM_W    = DIST_W + HITS_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [HITS_W-1:0] HIT_MAX = {HITS_W{1'b1}};

    // stream payload layout
    localparam int S_FIELDS_W = ANGLE_W + DIST_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 * ANGLE_W + DIST_W + HITS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_THRESHOLD_ADDR = 3'd0;
    localparam logic [DIST_W-1:0]     THRESHOLD_RESET    = 16'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FINAL,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic latch;
        logic apply_hit;
        logic snap;
        logic emit_last;
        logic clear_run;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic gap;
        logic run_open;
        logic scan_end;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

[design/sos_divider.sv]
// ----------------------------------------------------------------------------
// sos_divider
// Restoring divider, one quotient bit per cycle: run distance sum over hits.
// ----------------------------------------------------------------------------
module sos_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sos_pkg::SUM_W-1:0]   dividend,
    input  logic [sos_pkg::HITS_W-1:0]  divisor,
    output logic                        busy,
    output logic [sos_pkg::SUM_W-1:0]   quotient
);

    logic                           busy_reg, busy_next;
    logic [sos_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sos_pkg::SUM_W-1:0]      quo_reg, quo_next;
    logic [sos_pkg::HITS_W-1:0]     rem_reg, rem_next;
    logic [sos_pkg::HITS_W-1:0]     dsr_reg, dsr_next;
    logic [sos_pkg::HITS_W:0]       rem_sh;
    logic [sos_pkg::HITS_W:0]       rem_diff;
    logic                           fits;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[sos_pkg::SUM_W-1]};
        fits     = rem_sh >= {1'b0, dsr_reg};
        rem_diff = rem_sh - {1'b0, dsr_reg};

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[sos_pkg::SUM_W-2:0], fits};
            rem_next = fits ? rem_diff[sos_pkg::HITS_W-1:0] : rem_sh[sos_pkg::HITS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sos_pkg::DIV_CNT_W'(sos_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[design/sos_datapath.sv]
// ----------------------------------------------------------------------------
// sos_datapath
// Sample register, open-run accumulator, emit snapshot, divider and the
// output register of the obstacle segmenter.
// ----------------------------------------------------------------------------
module sos_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  sos_pkg::cmd_t                   cmd,
    output sos_pkg::status_t                status,
    input  logic [sos_pkg::DIST_W-1:0]      threshold,
    input  logic [sos_pkg::ANGLE_W-1:0]     in_angle,
    input  logic [sos_pkg::DIST_W-1:0]      in_distance,
    input  logic                            in_scan_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sos_pkg::M_TDATA_W-1:0]   out_data,
    output logic                            out_last
);

    // latched sample
    logic [sos_pkg::ANGLE_W-1:0]    angle_reg;
    logic [sos_pkg::DIST_W-1:0]     dist_reg;
    logic                           end_reg;

    // open run
    logic                           open_reg, open_next;
    logic [sos_pkg::ANGLE_W-1:0]    first_reg, first_next;
    logic [sos_pkg::ANGLE_W-1:0]    last_reg, last_next;
    logic [sos_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [sos_pkg::HITS_W-1:0]     hits_reg, hits_next;

    // snapshot of the run being emitted
    logic [sos_pkg::ANGLE_W-1:0]    e_first_reg;
    logic [sos_pkg::ANGLE_W-1:0]    e_last_reg;
    logic [sos_pkg::HITS_W-1:0]     e_hits_reg;
    logic                           e_lastres_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [sos_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic                           out_last_reg;

    logic                           hit;
    logic                           gap;
    logic                           div_busy;
    logic [sos_pkg::SUM_W-1:0]      quotient;
    logic [sos_pkg::ANGLE_W-1:0]    span;
    logic [sos_pkg::M_FIELDS_W-1:0] fields;

    assign hit = dist_reg < threshold;
    assign gap = {1'b0, angle_reg} > ({1'b0, last_reg} + 1'b1);

    always_comb
    begin
        open_next  = open_reg;
        first_next = first_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        hits_next  = hits_reg;
        if (cmd.apply_hit && hit)
        begin
            if (!open_reg || gap)
            begin
                // start a fresh run on this hit
                open_next  = 1'b1;
                first_next = angle_reg;
                last_next  = angle_reg;
                sum_next   = sos_pkg::SUM_W'(dist_reg);
                hits_next  = sos_pkg::HITS_W'(1);
            end
            else
            begin
                last_next = angle_reg;
                if (hits_reg != sos_pkg::HIT_MAX)
                begin
                    hits_next = hits_reg + 1'b1;
                    sum_next  = sum_reg + sos_pkg::SUM_W'(dist_reg);
                end
            end
        end
        else if (cmd.clear_run)
        begin
            open_next  = 1'b0;
            first_next = '0;
            last_next  = '0;
            sum_next   = '0;
            hits_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            first_reg <= '0;
            last_reg  <= '0;
            sum_reg   <= '0;
            hits_reg  <= '0;
        end
        else
        begin
            open_reg  <= open_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            sum_reg   <= sum_next;
            hits_reg  <= hits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            angle_reg <= in_angle;
            dist_reg  <= in_distance;
            end_reg   <= in_scan_end;
        end
        if (cmd.snap)
        begin
            e_first_reg   <= first_reg;
            e_last_reg    <= last_reg;
            e_hits_reg    <= hits_reg;
            e_lastres_reg <= cmd.emit_last;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= sos_pkg::M_TDATA_W'(fields);
            out_last_reg <= e_lastres_reg;
        end
    end

    sos_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.snap),
        .dividend (sum_reg),
        .divisor  (hits_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign span   = (e_last_reg >= e_first_reg) ? (e_last_reg - e_first_reg) : '0;
    assign fields = {e_hits_reg, quotient[sos_pkg::DIST_W-1:0], span, e_last_reg, e_first_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.hit      = hit;
    assign status.gap      = gap;
    assign status.run_open = open_reg;
    assign status.scan_end = end_reg;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

[design/sos_ctrl.sv]
// ----------------------------------------------------------------------------
// sos_ctrl
// Sequencer: take a sample, update the run, close runs through the divider.
// ----------------------------------------------------------------------------
module sos_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sos_pkg::status_t    status,
    output sos_pkg::cmd_t       cmd
);

    sos_pkg::state_t state_reg, state_next;
    logic            after_gap_reg, after_gap_next;

    always_comb
    begin
        state_next     = state_reg;
        after_gap_next = after_gap_reg;
        unique case (state_reg)
            sos_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sos_pkg::ST_CHECK;
                end
            end
            sos_pkg::ST_CHECK:
            begin
                if (status.hit && status.run_open && status.gap)
                begin
                    state_next     = sos_pkg::ST_DIV;
                    after_gap_next = 1'b1;
                end
                else
                begin
                    state_next = sos_pkg::ST_FINAL;
                end
            end
            sos_pkg::ST_FINAL:
            begin
                if (status.scan_end && status.run_open)
                begin
                    state_next     = sos_pkg::ST_DIV;
                    after_gap_next = 1'b0;
                end
                else
                begin
                    state_next = sos_pkg::ST_IDLE;
                end
            end
            sos_pkg::ST_DIV:
            begin
                if (!status.div_busy && status.out_free)
                begin
                    // a gap result still owes the end-of-scan check
                    state_next = after_gap_reg ? sos_pkg::ST_FINAL : sos_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sos_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            sos_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.latch    = in_valid;
            end
            sos_pkg::ST_CHECK:
            begin
                cmd.apply_hit = 1'b1;
                if (status.hit && status.run_open && status.gap)
                begin
                    cmd.snap      = 1'b1;
                    cmd.emit_last = !status.scan_end;
                end
            end
            sos_pkg::ST_FINAL:
            begin
                if (status.scan_end && status.run_open)
                begin
                    cmd.snap      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.clear_run = 1'b1;
                end
            end
            sos_pkg::ST_DIV:
            begin
                cmd.load_out = !status.div_busy && status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sos_pkg::ST_IDLE;
            after_gap_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_gap_reg <= after_gap_next;
        end
    end

endmodule

[design/scan_obstacle_segmenter_core.sv]
// ----------------------------------------------------------------------------
// scan_obstacle_segmenter_core
// Groups near range samples into obstacle runs and reports each closed run.
// ----------------------------------------------------------------------------
// Usage:
//   Feed samples in ascending angle order on the s_ stream: angle and distance
//   in s_tdata, s_tlast on the final sample of a scan. A sample nearer than
//   the threshold register (APB, address 0, reset 1000 mm) is a hit; a hit
//   more than one degree past the previous hit closes the open run, and
//   s_tlast closes whatever run is open. Each closed run leaves on the m_
//   stream; m_tlast marks the last result caused by one request.
//   Timing: a request that closes no run passes accept, update and end
//   check before the next is taken. Each closed run adds a pass through
//   the 25-bit sum/hits divider, one bit per cycle, plus the load into
//   the output register. The worst case is a gap on the final sample,
//   which closes two runs.
//   A result waits in the output register while m_tready is low; the next
//   request is still accepted, and only a further result stalls behind it.
//   Reset clears the open run, empties the output and restores the
//   threshold; write the threshold only while the block is idle.
// ----------------------------------------------------------------------------
module scan_obstacle_segmenter_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sos_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sos_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sos_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sos_pkg::S_TDATA_W-1:0]       s_tdata,  // angle[8:0], distance[24:9], zero pad
    input  logic                                s_tlast,  // scan_end
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // start_angle[8:0], end_angle[17:9], angle_span[26:18],
    // average_distance[42:27], sample_count[51:43], zero pad
    output logic [sos_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast   // last_result
);

    logic [sos_pkg::DIST_W-1:0] threshold_reg, threshold_next;
    logic                       cfg_wr;
    sos_pkg::cmd_t              cmd;
    sos_pkg::status_t           status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == sos_pkg::REG_THRESHOLD_ADDR);

    always_comb
    begin
        threshold_next = threshold_reg;
        if (cfg_wr)
        begin
            threshold_next = pwdata[sos_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= sos_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    assign prdata = (paddr == sos_pkg::REG_THRESHOLD_ADDR)
                  ? sos_pkg::APB_DATA_W'(threshold_reg) : '0;

    sos_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    sos_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .threshold   (threshold_reg),
        .in_angle    (s_tdata[sos_pkg::ANGLE_W-1:0]),
        .in_distance (s_tdata[sos_pkg::S_FIELDS_W-1:sos_pkg::ANGLE_W]),
        .in_scan_end (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_last    (m_tlast)
    );

    assign s_tready = cmd.in_ready;

    // one request at a time: nothing is taken right after an accept
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in work");

    // a reported run holds at least one hit
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[51:43] != 9'd0)
        else $error("result with zero sample count");

    // span agrees with the reported angles
    a_span_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[26:18] ==
            ((m_tdata[17:9] >= m_tdata[8:0]) ? (m_tdata[17:9] - m_tdata[8:0]) : 9'd0))
        else $error("angle span does not match start and end angles");

    // no new result lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !m_tvalid || m_tready)
        else $error("output register overwritten before it was taken");

endmodule

[tb/sv/scan_obstacle_segmenter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_obstacle_segmenter_core_tb
// Streams range scans through the segmenter under several threshold settings
// and checks every reported obstacle run against an in-bench model of the
// run tracking, with random stalls on both streams and two long output stalls.
// ----------------------------------------------------------------------------
module scan_obstacle_segmenter_core_tb;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int SAT_SAMPLES  = 530;

    typedef struct packed {
        logic [sos_pkg::ANGLE_W-1:0] start_angle;
        logic [sos_pkg::ANGLE_W-1:0] end_angle;
        logic [sos_pkg::ANGLE_W-1:0] angle_span;
        logic [sos_pkg::DIST_W-1:0]  average_distance;
        logic [sos_pkg::HITS_W-1:0]  sample_count;
        logic                        last_result;
    } obstacle_t;

    class obstacle_scoreboard;
        logic [sos_pkg::DIST_W-1:0]  threshold;
        bit                          run_open;
        logic [sos_pkg::ANGLE_W-1:0] first_angle;
        logic [sos_pkg::ANGLE_W-1:0] last_angle;
        logic [sos_pkg::SUM_W-1:0]   dist_sum;
        logic [sos_pkg::HITS_W-1:0]  hits;
        obstacle_t                   obstacles_due[$];
        int unsigned                 errors;

        function new();
            threshold   = sos_pkg::THRESHOLD_RESET;
            run_open    = 1'b0;
            first_angle = '0;
            last_angle  = '0;
            dist_sum    = '0;
            hits        = '0;
            errors      = 0;
        endfunction

        function int pending();
            return obstacles_due.size();
        endfunction

        function void start_run(logic [sos_pkg::ANGLE_W-1:0] angle,
                                logic [sos_pkg::DIST_W-1:0] sample_dist);
            run_open    = 1'b1;
            first_angle = angle;
            last_angle  = angle;
            dist_sum    = {{(sos_pkg::SUM_W-sos_pkg::DIST_W){1'b0}}, sample_dist};
            hits        = 1;
        endfunction

        function void close_run(bit last);
            obstacle_t                 o;
            logic [sos_pkg::SUM_W-1:0] quotient;
            quotient = '0;
            if (hits != 0)
                quotient = dist_sum / {{(sos_pkg::SUM_W-sos_pkg::HITS_W){1'b0}}, hits};
            o.start_angle      = first_angle;
            o.end_angle        = last_angle;
            o.angle_span       = (last_angle >= first_angle) ? last_angle - first_angle : '0;
            o.average_distance = quotient[sos_pkg::DIST_W-1:0];
            o.sample_count     = hits;
            o.last_result      = last;
            obstacles_due      = {obstacles_due, o};
        endfunction

        // Predict the runs closed by one accepted sample request.
        function void take_sample(logic [sos_pkg::ANGLE_W-1:0] angle,
                                  logic [sos_pkg::DIST_W-1:0] sample_dist,
                                  bit scan_end);
            if (sample_dist < threshold)
            begin
                if (!run_open)
                    start_run(angle, sample_dist);
                else if ({1'b0, angle} > {1'b0, last_angle} + 10'd1)
                begin
                    close_run(!scan_end);
                    start_run(angle, sample_dist);
                end
                else
                begin
                    // out-of-order hits also continue the run
                    last_angle = angle;
                    if (hits != sos_pkg::HIT_MAX)
                    begin
                        hits     = hits + 1'b1;
                        dist_sum = dist_sum
                                 + {{(sos_pkg::SUM_W-sos_pkg::DIST_W){1'b0}}, sample_dist};
                    end
                end
            end
            if (scan_end && run_open)
            begin
                close_run(1'b1);
                run_open    = 1'b0;
                first_angle = '0;
                last_angle  = '0;
                dist_sum    = '0;
                hits        = '0;
            end
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_obstacle(logic [sos_pkg::M_TDATA_W-1:0] word, logic tlast);
            obstacle_t want;
            if (obstacles_due.size() == 0)
            begin
                $error("obstacle with none pending: start_angle %0d end_angle %0d",
                       word[0 +: sos_pkg::ANGLE_W], word[sos_pkg::ANGLE_W +: sos_pkg::ANGLE_W]);
                errors++;
                return;
            end
            want = obstacles_due.pop_front();
            check_field("start_angle", 32'(want.start_angle),
                        32'(word[0 +: sos_pkg::ANGLE_W]));
            check_field("end_angle", 32'(want.end_angle),
                        32'(word[sos_pkg::ANGLE_W +: sos_pkg::ANGLE_W]));
            check_field("angle_span", 32'(want.angle_span),
                        32'(word[2*sos_pkg::ANGLE_W +: sos_pkg::ANGLE_W]));
            check_field("average_distance", 32'(want.average_distance),
                        32'(word[3*sos_pkg::ANGLE_W +: sos_pkg::DIST_W]));
            check_field("sample_count", 32'(want.sample_count),
                        32'(word[3*sos_pkg::ANGLE_W+sos_pkg::DIST_W +: sos_pkg::HITS_W]));
            check_field("last_result", 32'(want.last_result), 32'(tlast));
        endfunction
    endclass

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [sos_pkg::APB_ADDR_W-1:0]   paddr    = '0;
    logic [sos_pkg::APB_DATA_W-1:0]   pwdata   = '0;
    logic [sos_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [sos_pkg::S_TDATA_W-1:0]    s_tdata  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [sos_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                             m_tlast;

    obstacle_scoreboard obstacle_sb;
    bit                 idle_on  = 1'b1;
    bit                 hold_req = 1'b0;
    int unsigned        live_items;
    int unsigned        quiet_cycles = 0;

    scan_obstacle_segmenter_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // angle, distance, zero pad
        .s_tlast  (s_tlast),   // scan_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // start_angle, end_angle, angle_span, average_distance,
                               // sample_count, zero pad
        .m_tlast  (m_tlast)    // last_result
    );

    always #5 clk = ~clk;

    // Result side: random stall bursts, plus one long hold on request.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                m_tready  <= 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready  <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Check results and watch for a stuck block.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            obstacle_sb.check_obstacle(m_tdata, m_tlast);
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_sample(input logic [sos_pkg::ANGLE_W-1:0] angle,
                               input logic [sos_pkg::DIST_W-1:0] sample_dist,
                               input bit scan_end);
        int unsigned                   gap;
        logic [sos_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[0 +: sos_pkg::ANGLE_W]               = angle;
        word[sos_pkg::ANGLE_W +: sos_pkg::DIST_W] = sample_dist;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= scan_end;
        do
            @(posedge clk);
        while (!s_tready);
        obstacle_sb.take_sample(angle, sample_dist, scan_end);
    endtask

    task automatic stop_samples();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results();
        while (obstacle_sb.pending() != 0)
            @(posedge clk);
    endtask

    // Drain all results, then let a request that closes nothing finish.
    task automatic settle();
        stop_samples();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [sos_pkg::DIST_W-1:0] value);
        logic [sos_pkg::APB_DATA_W-1:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sos_pkg::REG_THRESHOLD_ADDR;
        pwdata  <= {{(sos_pkg::APB_DATA_W-sos_pkg::DIST_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        obstacle_sb.threshold = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        obstacle_sb.check_field("threshold_distance",
                                {{(sos_pkg::APB_DATA_W-sos_pkg::DIST_W){1'b0}}, value},
                                readback);
    endtask

    // Hits at a chosen percentage, with the threshold edges and field extremes mixed in.
    function automatic logic [sos_pkg::DIST_W-1:0] pick_distance(int unsigned hit_pct);
        int unsigned thr;
        int unsigned roll;
        thr  = 32'(obstacle_sb.threshold);
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return (thr == 0) ? '0 : sos_pkg::DIST_W'(thr - 1);
        if (roll < 6)
            return sos_pkg::DIST_W'(thr);
        if (roll < 8)
            return {sos_pkg::DIST_W{1'b1}};
        if (roll < 10)
            return '0;
        if (thr != 0 && $urandom_range(0, 99) < hit_pct)
            return sos_pkg::DIST_W'($urandom_range(0, thr - 1));
        return sos_pkg::DIST_W'($urandom_range(thr, 65535));
    endfunction

    task automatic random_scan(input int unsigned len);
        int unsigned                ang;
        int unsigned                hit_pct;
        int unsigned                roll;
        logic [sos_pkg::DIST_W-1:0] sample_dist;
        bit                         scan_end;
        ang     = $urandom_range(0, 200);
        hit_pct = $urandom_range(15, 90);
        for (int unsigned i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                ang = $urandom_range(0, 359);   // jump anywhere, backwards too
            else if (roll < 14)
                ang = ang;
            else if (roll < 64)
                ang = ang + 1;
            else if (roll < 82)
                ang = ang + 2;
            else
                ang = ang + $urandom_range(3, 24);
            if (ang > 359)
                ang = 359;
            sample_dist = pick_distance(hit_pct);
            scan_end    = (i == len - 1);
            // count every sample sent
            live_items++;
            send_sample(ang[sos_pkg::ANGLE_W-1:0], sample_dist, scan_end);
        end
    endtask

    task automatic run_phase(input int unsigned target, input bit calm);
        live_items = 0;
        while (live_items < target)
        begin
            idle_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
            random_scan(($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 40));
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                stop_samples();
                wait_results();
            end
        end
    endtask

    initial
    begin
        logic [sos_pkg::ANGLE_W-1:0] sat_angle;
        obstacle_sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // threshold at its reset value of 1000
        // empty scan
        send_sample(9'd10, 16'd5000, 1'b0);
        send_sample(9'd11, 16'd1000, 1'b1);
        // lone final hit
        send_sample(9'd20, 16'd999, 1'b1);
        // gap on the final sample: old run first, then the one-hit run
        send_sample(9'd30, 16'd0, 1'b0);
        send_sample(9'd31, 16'd500, 1'b0);
        send_sample(9'd40, 16'd999, 1'b1);
        // angles out of order: end angle below start angle, zero span
        send_sample(9'd100, 16'd10, 1'b0);
        send_sample(9'd50, 16'd20, 1'b0);
        send_sample(9'd51, 16'd30, 1'b1);
        // angle and distance extremes
        send_sample(9'd0, 16'd0, 1'b0);
        send_sample(9'd1, 16'd999, 1'b0);
        send_sample(9'd256, 16'hFFFF, 1'b0);
        send_sample(9'd359, 16'hFFFF, 1'b0);
        send_sample(9'd359, 16'd1, 1'b1);
        // gaps mid-scan: a miss between two hits still leaves a gap that closes the run
        send_sample(9'd200, 16'd5, 1'b0);
        send_sample(9'd205, 16'd6, 1'b0);
        send_sample(9'd206, 16'd40000, 1'b0);
        send_sample(9'd207, 16'd7, 1'b0);
        send_sample(9'd300, 16'd2000, 1'b1);
        settle();

        // nothing is a hit
        write_threshold(16'd0);
        repeat (6) random_scan($urandom_range(1, 12));
        settle();

        // everything but the top distance is a hit; one run saturates its count
        write_threshold(16'hFFFF);
        sat_angle = 9'd10;
        for (int i = 0; i < SAT_SAMPLES; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                sat_angle = sat_angle + 1'b1;
            send_sample(sat_angle, sos_pkg::DIST_W'($urandom_range(0, 65534)),
                        i == SAT_SAMPLES - 1);
        end
        stop_samples();
        wait_results();
        hold_req = 1'b1;
        run_phase(270, 1'b0);
        settle();

        write_threshold(16'd1);
        run_phase(220, 1'b0);
        settle();

        write_threshold(sos_pkg::DIST_W'($urandom_range(2, 65534)));
        hold_req = 1'b1;
        run_phase(270, 1'b0);
        settle();

        write_threshold(sos_pkg::THRESHOLD_RESET);
        run_phase(270, 1'b0);
        settle();

        write_threshold(sos_pkg::DIST_W'($urandom_range(2, 65534)));
        run_phase(270, 1'b1);
        idle_on = 1'b0;
        settle();

        if (obstacle_sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
